[rtl/sts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, widths and the emission order of the triangle subdivider.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int CoordW = 16;            // signed Q3.12 coordinate
	localparam int RadiusW = 15;           // unsigned Q3.12 radius
	localparam int IdxW = 20;              // vertex index counter width
	localparam int SumW = 17;              // per-axis edge sum
	localparam int SqW = 34;               // square of one axis sum
	localparam int SsW = 36;               // sum of three squares
	localparam int ProdW = 32;             // radius * |sum|
	localparam int RootW = 32;             // floor(sqrt(S * 2^28))
	localparam int NumW = 47;              // dividend of the scaling division
	localparam int QuoW = 16;              // quotient bits kept
	localparam int NumSlots = 6;           // three corners then three midpoints
	localparam int NumOut = 12;            // vertices emitted per triangle
	localparam int InDataW = 144;
	localparam int OutDataW = 72;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		logic   degen;
		coord_t z;
		coord_t y;
		coord_t x;
	} vertex_t;

	// slot codes
	localparam logic [2:0] SlotV1 = 3'd0;
	localparam logic [2:0] SlotV2 = 3'd1;
	localparam logic [2:0] SlotV3 = 3'd2;
	localparam logic [2:0] SlotM1 = 3'd3;
	localparam logic [2:0] SlotM2 = 3'd4;
	localparam logic [2:0] SlotM3 = 3'd5;

	// emission order: V1 M1 M3 | M1 V2 M2 | M1 M2 M3 | M3 M2 V3
	function automatic logic [2:0] seq_slot(input logic [3:0] k);
		logic [2:0] s;
		unique case (k)
			4'd0:    s = SlotV1;
			4'd1:    s = SlotM1;
			4'd2:    s = SlotM3;
			4'd3:    s = SlotM1;
			4'd4:    s = SlotV2;
			4'd5:    s = SlotM2;
			4'd6:    s = SlotM1;
			4'd7:    s = SlotM2;
			4'd8:    s = SlotM3;
			4'd9:    s = SlotM3;
			4'd10:   s = SlotM2;
			4'd11:   s = SlotV3;
			default: s = SlotV1;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[rtl/sts_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sts_lane
// One midpoint core: sums two vertices, takes the length by a bit-serial
// square root and scales each axis to the radius by bit-serial division.
// ----------------------------------------------------------------------------
module sts_lane
	import sts_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               ack,
	input  wire logic [RadiusW-1:0] radius,
	input  wire vertex_t            va,
	input  wire vertex_t            vb,
	output vertex_t                 mid,
	output logic                    done
);

	typedef enum logic [2:0] {
		LN_IDLE, LN_SQ, LN_SUM, LN_ROOT, LN_PREP, LN_DIV, LN_FIN, LN_HOLD
	} lane_state_t;

	lane_state_t              state_q;
	logic signed [SumW-1:0]   s_q    [3];
	logic [SqW-1:0]           sq_q   [3];
	logic [ProdW-1:0]         prod_q [3];
	logic [63:0]              n_q;
	logic [SqW-1:0]           rem_q;
	logic [RootW-1:0]         root_q;
	logic [4:0]               cnt_q;
	logic [RootW:0]           drem_q [3];
	logic [QuoW-1:0]          num_q  [3];
	logic [QuoW-1:0]          quo_q  [3];
	logic                     sat_q  [3];
	vertex_t                  mid_q;

	logic signed [SumW-1:0]   s_in   [3];
	logic [SumW-1:0]          mag    [3];
	logic [SsW-1:0]           sum_sq;
	logic [SsW-1:0]           rem_sh;
	logic [SsW-1:0]           trial;
	logic [NumW-1:0]          numer  [3];
	logic                     sat_n  [3];
	logic [RootW:0]           d_sh   [3];
	logic                     d_ge   [3];
	coord_t                   coord  [3];

	// edge sums and magnitudes
	always_comb begin
		s_in[0] = SumW'(va.x) + SumW'(vb.x);
		s_in[1] = SumW'(va.y) + SumW'(vb.y);
		s_in[2] = SumW'(va.z) + SumW'(vb.z);
		for (int i = 0; i < 3; i++) begin
			mag[i] = s_q[i][SumW-1] ? SumW'(-s_q[i]) : SumW'(s_q[i]);
		end
		sum_sq = SsW'(sq_q[0]) + SsW'(sq_q[1]) + SsW'(sq_q[2]);
	end

	// one square root step: two radicand bits per cycle
	always_comb begin
		rem_sh = {rem_q, n_q[63:62]};
		trial  = {2'b00, root_q, 2'b01};
	end

	// scaling dividend, overflow check and one division step per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			numer[i] = {1'b0, prod_q[i], 14'b0} + NumW'(root_q[RootW-1:1]);
			sat_n[i] = {1'b0, numer[i]} >= {root_q, 16'b0};
			d_sh[i]  = {drem_q[i][RootW-1:0], num_q[i][QuoW-1]};
			d_ge[i]  = d_sh[i] >= {1'b0, root_q};
		end
	end

	// sign and saturation of the quotients
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (s_q[i][SumW-1]) begin
				if (sat_q[i] || quo_q[i] > 16'd32768) coord[i] = 16'sh8000;
				else                                  coord[i] = coord_t'(~quo_q[i] + 16'd1);
			end else begin
				if (sat_q[i] || quo_q[i][QuoW-1]) coord[i] = 16'sh7fff;
				else                              coord[i] = coord_t'(quo_q[i]);
			end
		end
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LN_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				LN_IDLE: begin
					if (start) begin
						for (int i = 0; i < 3; i++) s_q[i] <= s_in[i];
						state_q <= LN_SQ;
					end
				end
				LN_SQ: begin
					for (int i = 0; i < 3; i++) begin
						sq_q[i]   <= SqW'(mag[i]) * SqW'(mag[i]);
						prod_q[i] <= ProdW'(radius) * ProdW'(mag[i]);
					end
					state_q <= LN_SUM;
				end
				LN_SUM: begin
					n_q    <= {sum_sq, 28'b0};
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= '0;
					if (sum_sq == '0) begin
						mid_q   <= '{degen: 1'b1, z: '0, y: '0, x: '0};
						state_q <= LN_HOLD;
					end else begin
						state_q <= LN_ROOT;
					end
				end
				LN_ROOT: begin
					if (rem_sh >= trial) begin
						rem_q  <= SqW'(rem_sh - trial);
						root_q <= {root_q[RootW-2:0], 1'b1};
					end else begin
						rem_q  <= SqW'(rem_sh);
						root_q <= {root_q[RootW-2:0], 1'b0};
					end
					n_q   <= {n_q[61:0], 2'b00};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= LN_PREP;
				end
				LN_PREP: begin
					for (int i = 0; i < 3; i++) begin
						sat_q[i]  <= sat_n[i];
						drem_q[i] <= {2'b00, numer[i][NumW-1:QuoW]};
						num_q[i]  <= numer[i][QuoW-1:0];
						quo_q[i]  <= '0;
					end
					cnt_q   <= '0;
					state_q <= LN_DIV;
				end
				LN_DIV: begin
					for (int i = 0; i < 3; i++) begin
						drem_q[i] <= d_ge[i] ? d_sh[i] - {1'b0, root_q} : d_sh[i];
						num_q[i]  <= {num_q[i][QuoW-2:0], 1'b0};
						quo_q[i]  <= {quo_q[i][QuoW-2:0], d_ge[i]};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) state_q <= LN_FIN;
				end
				LN_FIN: begin
					mid_q   <= '{degen: 1'b0, z: coord[2], y: coord[1], x: coord[0]};
					state_q <= LN_HOLD;
				end
				LN_HOLD: begin
					if (ack) state_q <= LN_IDLE;
				end
				default: state_q <= LN_IDLE;
			endcase
		end
	end

	assign mid  = mid_q;
	assign done = (state_q == LN_HOLD);

endmodule
`default_nettype wire

[rtl/sts_emit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sts_emit
// Merge stage: holds the six vertices of one triangle and sends the twelve
// output vertices in mesh order with a running index.
// ----------------------------------------------------------------------------
module sts_emit
	import sts_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    load,
	input  wire logic                    level_start,
	input  wire vertex_t [NumSlots-1:0]  slots,
	output logic                         load_ready,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [OutDataW-1:0]          m_tdata,
	output logic                         m_tuser,
	output logic                         m_tlast
);

	vertex_t [NumSlots-1:0] slots_q;
	logic                   emitting_q;
	logic [3:0]             k_q;
	logic [IdxW-1:0]        cnt_q;
	logic                   out_valid_q;
	vertex_t                out_vtx_q;
	logic [IdxW-1:0]        out_idx_q;
	logic                   out_last_q;
	logic                   push;
	vertex_t                cur;

	assign push       = emitting_q && (!out_valid_q || m_tready);
	assign load_ready = !emitting_q;
	assign cur        = slots_q[seq_slot(k_q)];

	// vertex store, sequence counter, index counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitting_q  <= 1'b0;
			k_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				slots_q    <= slots;
				emitting_q <= 1'b1;
				k_q        <= '0;
				if (level_start) cnt_q <= '0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
				out_vtx_q   <= cur;
				out_idx_q   <= cnt_q;
				out_last_q  <= (k_q == 4'(NumOut - 1));
				cnt_q       <= cnt_q + IdxW'(1);
				k_q         <= k_q + 4'd1;
				if (k_q == 4'(NumOut - 1)) emitting_q <= 1'b0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_idx_q, out_vtx_q.z, out_vtx_q.y, out_vtx_q.x};
	assign m_tuser  = out_vtx_q.degen;
	assign m_tlast  = out_last_q;

	// a new triangle is only taken between runs
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !emitting_q) else $error("triangle loaded during a run");

	// sequence position stays inside the run
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		emitting_q |-> k_q <= 4'(NumOut - 1)) else $error("sequence position out of range");

	// the twelfth vertex carries tlast
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && k_q == 4'(NumOut - 1) |=> out_last_q && !emitting_q)
		else $error("run end not marked");

	// a level start restarts the index
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		load && level_start |=> cnt_q == '0) else $error("index not cleared");

endmodule
`default_nettype wire

[rtl/sphere_triangle_subdivider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider
// Splits one sphere mesh triangle into four, with midpoints pushed to radius.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* takes one triangle a transfer: s_tdata holds first x/y/z, second
//    x/y/z, third x/y/z (16 bit each, lowest first), s_tuser is level_start.
//  - m_* sends twelve vertices per triangle: V1 M1 M3, M1 V2 M2, M1 M2 M3,
//    M3 M2 V3. tlast marks the twelfth, tuser flags a zero-length edge sum.
//  - cfg_* writes sphere_radius; write it only while the block is idle.
//  - three midpoint lanes run side by side. each takes the square root (two
//    bits a cycle), then the scaling division (one bit a cycle), with setup
//    states before, between and after them; the results are then handed
//    over and loaded into the output register. a lane whose edge sum is
//    zero skips the root and the division. a new triangle is accepted only
//    once the lanes have handed over the results of the last one.
//  - the twelve vertices of one triangle leave from an output register while
//    the lanes already work on the next one.
//  - reset clears the index counter and sets the radius to 1.0.
//  - when m_tready is low, the output register holds and the lanes finish
//    and wait; s_tready stays low until their results are handed over.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider
	import sts_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [RadiusW-1:0]  cfg_data,     // sphere_radius
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z,
	// third_x, third_y, third_z
	input  wire logic [InDataW-1:0]  s_tdata,
	input  wire logic                s_tuser,      // level_start
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// out_x, out_y, out_z, vertex_index, 4 bits zero fill
	output logic [OutDataW-1:0]      m_tdata,
	output logic                     m_tuser,      // degenerate
	output logic                     m_tlast       // last_of_run
);

	logic [RadiusW-1:0]     radius_q;
	logic                   busy_q;
	logic                   level_q;
	vertex_t [2:0]          corner_q;
	vertex_t [2:0]          in_vtx;
	vertex_t [2:0]          mid;
	logic [2:0]             lane_done;
	logic                   start;
	logic                   handoff;
	logic                   load_ready;
	vertex_t [NumSlots-1:0] slots;

	// unpack the three corners
	always_comb begin
		for (int v = 0; v < 3; v++) begin
			in_vtx[v].x     = coord_t'(s_tdata[CoordW*(3*v)   +: CoordW]);
			in_vtx[v].y     = coord_t'(s_tdata[CoordW*(3*v+1) +: CoordW]);
			in_vtx[v].z     = coord_t'(s_tdata[CoordW*(3*v+2) +: CoordW]);
			in_vtx[v].degen = 1'b0;
		end
	end

	assign s_tready  = !busy_q;
	assign start     = s_tvalid && s_tready;
	assign handoff   = busy_q && (&lane_done) && load_ready;
	assign cfg_ready = 1'b1;

	// radius register, corner hold and front-end busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RadiusW'(4096);
			busy_q   <= 1'b0;
		end else begin
			if (cfg_valid) radius_q <= cfg_data;
			if (start) begin
				busy_q   <= 1'b1;
				corner_q <= in_vtx;
				level_q  <= s_tuser;
			end else if (handoff) begin
				busy_q <= 1'b0;
			end
		end
	end

	// midpoint lanes: M1 from V1,V2  M2 from V2,V3  M3 from V1,V3
	sts_lane u_lane_m1 (
		.clk(clk), .arst_n(arst_n), .start(start), .ack(handoff), .radius(radius_q),
		.va(in_vtx[0]), .vb(in_vtx[1]), .mid(mid[0]), .done(lane_done[0])
	);
	sts_lane u_lane_m2 (
		.clk(clk), .arst_n(arst_n), .start(start), .ack(handoff), .radius(radius_q),
		.va(in_vtx[1]), .vb(in_vtx[2]), .mid(mid[1]), .done(lane_done[1])
	);
	sts_lane u_lane_m3 (
		.clk(clk), .arst_n(arst_n), .start(start), .ack(handoff), .radius(radius_q),
		.va(in_vtx[0]), .vb(in_vtx[2]), .mid(mid[2]), .done(lane_done[2])
	);

	assign slots = {mid[2], mid[1], mid[0], corner_q[2], corner_q[1], corner_q[0]};

	// merge and emit
	sts_emit u_emit (
		.clk(clk), .arst_n(arst_n), .load(handoff), .level_start(level_q),
		.slots(slots), .load_ready(load_ready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule
`default_nettype wire
